// ----- hdl/e2q_pkg.sv -----
// Shared types, constants and fixed-point helpers of the Euler-to-quaternion core.
// No dependencies.
`timescale 1ns / 1ps
package e2q_pkg;
  localparam int AngleBits = 16;
  localparam int CompBits  = 16;
  localparam int AngleFrac = AngleBits - 3;
  localparam int CordicSteps = 30;
  localparam int IntW = 34;
  localparam int OutShift = 30 - (CompBits - 2);
  localparam logic signed [IntW-1:0] CordicGain = IntW'(34'sh026DD3B6A);
  localparam logic signed [AngleBits-1:0] AngleLim =
    AngleBits'(longint'((64'd7244019458077122842 + (64'd1 << (60 - AngleFrac)))
                        >> (61 - AngleFrac)));

  typedef logic signed [IntW-1:0] q30_t;

  typedef struct packed {
    q30_t s;
    q30_t c;
  } sincos_t;

  function automatic q30_t atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    begin
      case (idx)
        5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;  5'd2: v = 32'h0FADBAFC;
        5'd3: v = 32'h07F56EA6;  5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
        5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;  5'd8: v = 32'h003FFFEA;
        5'd9: v = 32'h001FFFFD;  5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
        5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF; 5'd14: v = 32'h0000FFFF;
        5'd15: v = 32'h00007FFF; 5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
        5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF; 5'd20: v = 32'h000003FF;
        5'd21: v = 32'h000001FF; 5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
        5'd24: v = 32'h0000003F; 5'd25: v = 32'h0000001F; 5'd26: v = 32'h0000000F;
        5'd27: v = 32'h00000008; 5'd28: v = 32'h00000004; 5'd29: v = 32'h00000002;
        default: v = 32'h0;
      endcase
      atan_lut = q30_t'({2'b00, v});
    end
  endfunction
endpackage

// ----- hdl/e2q_cordic_lane.sv -----
// One angle lane: clamp, half-angle scaling and a 30-stage CORDIC pipeline.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_cordic_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [e2q_pkg::AngleBits-1:0] angle_i,
  output e2q_pkg::sincos_t                    sc_o
);
  import e2q_pkg::*;

  q30_t x_q [CordicSteps+1];
  q30_t y_q [CordicSteps+1];
  q30_t z_q [CordicSteps+1];
  logic signed [AngleBits-1:0] clamped;

  always_comb begin
    clamped = angle_i;
    if (angle_i > AngleLim) clamped = AngleLim;
    if (angle_i < -AngleLim) clamped = -AngleLim;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CordicGain;
      y_q[0] <= '0;
      z_q[0] <= q30_t'(clamped) <<< (29 - AngleFrac);
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][IntW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_lut(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_lut(5'(i));
        end
      end
    end
  end

  assign sc_o.s = y_q[CordicSteps];
  assign sc_o.c = x_q[CordicSteps];
endmodule

// ----- hdl/e2q_merge.sv -----
// Merging stage: triple products, sums and output rounding with saturation.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_merge (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  e2q_pkg::sincos_t                   roll_i,
  input  e2q_pkg::sincos_t                   pitch_i,
  input  e2q_pkg::sincos_t                   yaw_i,
  output logic signed [e2q_pkg::CompBits-1:0] w_o,
  output logic signed [e2q_pkg::CompBits-1:0] x_o,
  output logic signed [e2q_pkg::CompBits-1:0] y_o,
  output logic signed [e2q_pkg::CompBits-1:0] z_o
);
  import e2q_pkg::*;

  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [2*IntW-1:0] p;
    begin
      p = a * b + (2*IntW)'(64'sd1 <<< 29);
      mulq = q30_t'(p >>> 30);
    end
  endfunction

  function automatic logic signed [CompBits-1:0] out_fmt(input q30_t v);
    logic signed [IntW:0] r;
    begin
      r = (IntW+1)'(v);
      if (OutShift > 0) r = (r + ((IntW+1)'(1) <<< (OutShift - 1))) >>> OutShift;
      if (r > (IntW+1)'((64'sd1 <<< (CompBits-1)) - 1))
        r = (IntW+1)'((64'sd1 <<< (CompBits-1)) - 1);
      if (r < -(IntW+1)'(64'sd1 <<< (CompBits-1)))
        r = -(IntW+1)'(64'sd1 <<< (CompBits-1));
      out_fmt = r[CompBits-1:0];
    end
  endfunction

  // pair products: cr*cp, sr*sp, sr*cp, cr*sp
  q30_t cc_q, ss_q, sc_q, cs_q, cy_q, sy_q;
  q30_t t_q [8];
  q30_t w_q, x_q, y_q, z_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= mulq(roll_i.c, pitch_i.c);
      ss_q <= mulq(roll_i.s, pitch_i.s);
      sc_q <= mulq(roll_i.s, pitch_i.c);
      cs_q <= mulq(roll_i.c, pitch_i.s);
      cy_q <= yaw_i.c;
      sy_q <= yaw_i.s;
      t_q[0] <= mulq(cc_q, cy_q);
      t_q[1] <= mulq(ss_q, sy_q);
      t_q[2] <= mulq(sc_q, cy_q);
      t_q[3] <= mulq(cs_q, sy_q);
      t_q[4] <= mulq(cs_q, cy_q);
      t_q[5] <= mulq(sc_q, sy_q);
      t_q[6] <= mulq(cc_q, sy_q);
      t_q[7] <= mulq(ss_q, cy_q);
      w_q <= t_q[0] + t_q[1];
      x_q <= t_q[2] - t_q[3];
      y_q <= t_q[4] + t_q[5];
      z_q <= t_q[6] - t_q[7];
      w_o <= out_fmt(w_q);
      x_o <= out_fmt(x_q);
      y_o <= out_fmt(y_q);
      z_o <= out_fmt(z_q);
    end
  end
endmodule

// ----- hdl/euler_to_quaternion_core.sv -----
// Euler angles (roll, pitch, yaw) to unit quaternion, three CORDIC lanes and a merge stage.
// Throughput one word per cycle while the output word is not stalled.
// Depth is set by the 31 CORDIC lane registers plus 4 merge registers.
// The pipeline advances whenever the output register is empty or being taken.
// rst_ni clears the valid pipeline asynchronously; data registers are not reset.
// Depends on e2q_pkg, e2q_cordic_lane and e2q_merge.
`timescale 1ns / 1ps
module euler_to_quaternion_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [e2q_pkg::AngleBits-1:0] roll_angle_i,
  input  logic signed [e2q_pkg::AngleBits-1:0] pitch_angle_i,
  input  logic signed [e2q_pkg::AngleBits-1:0] yaw_angle_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [e2q_pkg::CompBits-1:0] quat_w_o,
  output logic signed [e2q_pkg::CompBits-1:0] quat_x_o,
  output logic signed [e2q_pkg::CompBits-1:0] quat_y_o,
  output logic signed [e2q_pkg::CompBits-1:0] quat_z_o
);
  import e2q_pkg::*;

  localparam int Depth = CordicSteps + 1 + 4;

  logic [Depth-1:0] vld_q;
  logic en;
  sincos_t sc_r, sc_p, sc_y;

  assign en = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  e2q_cordic_lane u_roll (.clk_i, .en_i(en), .angle_i(roll_angle_i), .sc_o(sc_r));
  e2q_cordic_lane u_pitch (.clk_i, .en_i(en), .angle_i(pitch_angle_i), .sc_o(sc_p));
  e2q_cordic_lane u_yaw (.clk_i, .en_i(en), .angle_i(yaw_angle_i), .sc_o(sc_y));

  e2q_merge u_merge (
    .clk_i, .en_i(en), .roll_i(sc_r), .pitch_i(sc_p), .yaw_i(sc_y),
    .w_o(quat_w_o), .x_o(quat_x_o), .y_o(quat_y_o), .z_o(quat_z_o)
  );

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quat_w_o) && $stable(quat_z_o))
    else $error("output word changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !vld_q[Depth-2] |=> !out_valid_o)
    else $error("output word appeared without source");
endmodule
